>>> hw/rtl/orl_pkg.sv
// Package for the ordered record list: sizes, command codes and status codes.
// Used by ordered_record_list; depends on nothing else.
package orl_pkg;

    // Capacity of the list in records.
    localparam int DEPTH = 16;

    // Derived widths: an entry index, and a count that can hold DEPTH itself.
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Fixed field widths of the ports.
    localparam int CMD_W = 3;
    localparam int POS_IN_W = 8;
    localparam int KEY_W = 32;
    localparam int AGE_W = 8;
    localparam int STATUS_W = 3;
    localparam int POS_OUT_W = 7;
    localparam int COUNT_OUT_W = 7;

    // One stored record: key in the upper bits, age in the lower bits.
    localparam int ENT_W = KEY_W + AGE_W;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_POS = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_HEAD = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_TAIL = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DEL_POS = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd6;
    localparam logic [CMD_W-1:0] CMD_DISPLAY = 3'd7;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL = 3'd5;

endpackage

>>> hw/rtl/ordered_record_list.sv
// Ordered record list: a bounded list of key/age records kept in head-first order.
// Holds the record memory, the command sequencer and the result register.
// Depends on orl_pkg.
//
// The block keeps up to DEPTH records (16) in the record memory in list
// order, the head at address 0. One command beat is accepted while in_stall is
// low; the block then raises in_stall until the command is finished. All
// record movement goes through one memory read port and one write port, one
// entry at a time, so the cost of a command is set by how many entries
// it has to walk and by any wait on out_stall. Errors (empty, invalid
// position, out of range, full) are answered without touching the memory.
// Every command produces at least one result beat and its final beat carries
// last = 1; display produces one beat per record, head first. The result sits
// in an output register, so a new command beat can be accepted while the last
// result of the previous one still waits for the consumer. Records that were
// never written are never read. count_out always reports the record count
// after the command. There is no clearing pass after reset.
module ordered_record_list
    import orl_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Command channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [CMD_W-1:0]              command,
    input  logic [POS_IN_W-1:0]           position,
    input  logic signed [KEY_W-1:0]       key,
    input  logic [AGE_W-1:0]              age_in,
    // Result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [STATUS_W-1:0]           status,
    output logic [POS_OUT_W-1:0]          found_position,
    output logic signed [KEY_W-1:0]       key_out,
    output logic [AGE_W-1:0]              age_out,
    output logic [COUNT_OUT_W-1:0]        count_out,
    output logic                          last
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EMIT,
        S_INS_STEP,
        S_INS_WR,
        S_DEL_CAP,
        S_DEL_STEP,
        S_DEL_WR,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DISP_RD,
        S_DISP_OUT
    } state_t;

    // Record memory and its registered read data.
    logic [ENT_W-1:0] mem [DEPTH];
    logic [ENT_W-1:0] rd_data_reg;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [ENT_W-1:0] mem_wdata;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;

    // Sequencer state.
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] tgt_reg, tgt_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [AGE_W-1:0] age_reg, age_next;

    // Result prepared for the single-beat answers.
    logic [STATUS_W-1:0]  pend_status_reg, pend_status_next;
    logic [POS_OUT_W-1:0] pend_pos_reg, pend_pos_next;
    logic [KEY_W-1:0]     pend_key_reg, pend_key_next;
    logic [AGE_W-1:0]     pend_age_reg, pend_age_next;

    // Output register.
    logic                   out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [POS_OUT_W-1:0]   found_position_reg, found_position_next;
    logic [KEY_W-1:0]       key_out_reg, key_out_next;
    logic [AGE_W-1:0]       age_out_reg, age_out_next;
    logic [COUNT_OUT_W-1:0] count_out_reg, count_out_next;
    logic                   last_reg, last_next;

    logic out_free;
    logic [KEY_W-1:0] rd_key;
    logic [AGE_W-1:0] rd_age;

    assign out_free = !out_valid_reg || !out_stall;
    assign rd_key = rd_data_reg[ENT_W-1:AGE_W];
    assign rd_age = rd_data_reg[AGE_W-1:0];

    always_comb
    begin
        logic [POS_IN_W-1:0] pos_m1;
        logic [CNT_W-1:0]    tgt_sel;
        logic [CNT_W-1:0]    ptr_inc;
        logic [CNT_W-1:0]    ptr_dec;

        pos_m1 = position - POS_IN_W'(1);
        tgt_sel = '0;
        ptr_inc = ptr_reg + CNT_W'(1);
        ptr_dec = ptr_reg - CNT_W'(1);

        state_next = state_reg;
        count_next = count_reg;
        ptr_next = ptr_reg;
        tgt_next = tgt_reg;
        key_next = key_reg;
        age_next = age_reg;
        pend_status_next = pend_status_reg;
        pend_pos_next = pend_pos_reg;
        pend_key_next = pend_key_reg;
        pend_age_next = pend_age_reg;

        out_valid_next = out_valid_reg && out_stall;
        status_next = status_reg;
        found_position_next = found_position_reg;
        key_out_next = key_out_reg;
        age_out_next = age_out_reg;
        count_out_next = count_out_reg;
        last_next = last_reg;

        mem_we = 1'b0;
        mem_waddr = ptr_reg[IDX_W-1:0];
        mem_wdata = rd_data_reg;
        rd_en = 1'b0;
        rd_addr = ptr_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    key_next = key;
                    age_next = age_in;
                    ptr_next = '0;
                    pend_status_next = ST_OK;
                    pend_pos_next = '0;
                    pend_key_next = '0;
                    pend_age_next = '0;
                    case (command)
                        CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS:
                        begin
                            if (command == CMD_INS_POS && position == '0)
                            begin
                                pend_status_next = ST_INVALID;
                                state_next = S_EMIT;
                            end
                            else if (count_reg == CNT_W'(DEPTH))
                            begin
                                pend_status_next = ST_FULL;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                if (command == CMD_INS_HEAD)
                                    tgt_sel = '0;
                                else if (command == CMD_INS_TAIL)
                                    tgt_sel = count_reg;
                                else if (pos_m1 > POS_IN_W'(count_reg))
                                    tgt_sel = count_reg;
                                else
                                    tgt_sel = pos_m1[CNT_W-1:0];
                                tgt_next = tgt_sel;
                                ptr_next = count_reg;
                                state_next = S_INS_STEP;
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                pend_status_next = ST_EMPTY;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                case (command)
                                    CMD_DEL_HEAD, CMD_DEL_TAIL, CMD_DEL_POS:
                                    begin
                                        if (command == CMD_DEL_POS && position == '0)
                                        begin
                                            pend_status_next = ST_INVALID;
                                            state_next = S_EMIT;
                                        end
                                        else if (command == CMD_DEL_POS &&
                                                 position > POS_IN_W'(count_reg))
                                        begin
                                            pend_status_next = ST_RANGE;
                                            state_next = S_EMIT;
                                        end
                                        else
                                        begin
                                            if (command == CMD_DEL_HEAD)
                                                tgt_sel = '0;
                                            else if (command == CMD_DEL_TAIL)
                                                tgt_sel = count_reg - CNT_W'(1);
                                            else
                                                tgt_sel = pos_m1[CNT_W-1:0];
                                            tgt_next = tgt_sel;
                                            rd_en = 1'b1;
                                            rd_addr = tgt_sel[IDX_W-1:0];
                                            state_next = S_DEL_CAP;
                                        end
                                    end
                                    CMD_SEARCH:
                                        state_next = S_SRCH_RD;
                                    CMD_DISPLAY:
                                        state_next = S_DISP_RD;
                                    default:
                                        state_next = S_IDLE;
                                endcase
                            end
                        end
                    endcase
                end
            end

            // Insert: move records up one place from the tail down to the
            // target, then write the new record into the gap.
            S_INS_STEP:
            begin
                if (ptr_reg == tgt_reg)
                begin
                    mem_we = 1'b1;
                    mem_waddr = ptr_reg[IDX_W-1:0];
                    mem_wdata = {key_reg, age_reg};
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_EMIT;
                end
                else
                begin
                    rd_en = 1'b1;
                    rd_addr = ptr_dec[IDX_W-1:0];
                    state_next = S_INS_WR;
                end
            end

            S_INS_WR:
            begin
                mem_we = 1'b1;
                mem_waddr = ptr_reg[IDX_W-1:0];
                mem_wdata = rd_data_reg;
                ptr_next = ptr_dec;
                state_next = S_INS_STEP;
            end

            // Delete: capture the victim, then close the gap record by record.
            S_DEL_CAP:
            begin
                pend_status_next = ST_OK;
                pend_pos_next = POS_OUT_W'(tgt_reg) + POS_OUT_W'(1);
                pend_key_next = rd_key;
                pend_age_next = rd_age;
                ptr_next = tgt_reg;
                state_next = S_DEL_STEP;
            end

            S_DEL_STEP:
            begin
                if (ptr_inc >= count_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_EMIT;
                end
                else
                begin
                    rd_en = 1'b1;
                    rd_addr = ptr_inc[IDX_W-1:0];
                    state_next = S_DEL_WR;
                end
            end

            S_DEL_WR:
            begin
                mem_we = 1'b1;
                mem_waddr = ptr_reg[IDX_W-1:0];
                mem_wdata = rd_data_reg;
                ptr_next = ptr_inc;
                state_next = S_DEL_STEP;
            end

            // Search: read and compare one record at a time from the head.
            S_SRCH_RD:
            begin
                if (ptr_reg == count_reg)
                begin
                    pend_status_next = ST_NOTFOUND;
                    state_next = S_EMIT;
                end
                else
                begin
                    rd_en = 1'b1;
                    rd_addr = ptr_reg[IDX_W-1:0];
                    state_next = S_SRCH_CMP;
                end
            end

            S_SRCH_CMP:
            begin
                if (rd_key == key_reg)
                begin
                    pend_status_next = ST_OK;
                    pend_pos_next = POS_OUT_W'(ptr_reg) + POS_OUT_W'(1);
                    pend_key_next = rd_key;
                    pend_age_next = rd_age;
                    state_next = S_EMIT;
                end
                else
                begin
                    ptr_next = ptr_inc;
                    state_next = S_SRCH_RD;
                end
            end

            // Display: one result beat per record, head first.
            S_DISP_RD:
            begin
                rd_en = 1'b1;
                rd_addr = ptr_reg[IDX_W-1:0];
                state_next = S_DISP_OUT;
            end

            S_DISP_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next = ST_OK;
                    found_position_next = POS_OUT_W'(ptr_reg) + POS_OUT_W'(1);
                    key_out_next = rd_key;
                    age_out_next = rd_age;
                    count_out_next = COUNT_OUT_W'(count_reg);
                    last_next = (ptr_inc == count_reg);
                    if (ptr_inc == count_reg)
                        state_next = S_IDLE;
                    else
                    begin
                        ptr_next = ptr_inc;
                        state_next = S_DISP_RD;
                    end
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next = pend_status_reg;
                    found_position_next = pend_pos_reg;
                    key_out_next = pend_key_reg;
                    age_out_next = pend_age_reg;
                    count_out_next = COUNT_OUT_W'(count_reg);
                    last_next = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ptr_reg <= '0;
            tgt_reg <= '0;
            key_reg <= '0;
            age_reg <= '0;
            pend_status_reg <= ST_OK;
            pend_pos_reg <= '0;
            pend_key_reg <= '0;
            pend_age_reg <= '0;
            out_valid_reg <= 1'b0;
            status_reg <= ST_OK;
            found_position_reg <= '0;
            key_out_reg <= '0;
            age_out_reg <= '0;
            count_out_reg <= '0;
            last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg <= ptr_next;
            tgt_reg <= tgt_next;
            key_reg <= key_next;
            age_reg <= age_next;
            pend_status_reg <= pend_status_next;
            pend_pos_reg <= pend_pos_next;
            pend_key_reg <= pend_key_next;
            pend_age_reg <= pend_age_next;
            out_valid_reg <= out_valid_next;
            status_reg <= status_next;
            found_position_reg <= found_position_next;
            key_out_reg <= key_out_next;
            age_out_reg <= age_out_next;
            count_out_reg <= count_out_next;
            last_reg <= last_next;
        end
    end

    // Record memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign found_position = found_position_reg;
    assign key_out = key_out_reg;
    assign age_out = age_out_reg;
    assign count_out = count_out_reg;
    assign last = last_reg;

`ifndef SYNTHESIS
    // The record count never goes past capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("record count above capacity");

    // Whenever the record count changes, it changes by exactly one record.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |->
            (count_reg == $past(count_reg) + CNT_W'(1)) ||
            (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("record count jumped by more than one");

    // The memory is written only by the insert and delete walks.
    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_INS_STEP) || (state_reg == S_INS_WR) ||
                   (state_reg == S_DEL_WR))
        else $error("record memory written outside insert or delete");

    // An insert shift step always stays above its target slot.
    a_ins_above_target: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS_WR) |-> (ptr_reg > tgt_reg))
        else $error("insert shift walked past its target");

    // A delete shift step always stays inside the occupied records.
    a_del_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DEL_WR) |-> ({1'b0, ptr_reg} + 1'b1 < {1'b0, count_reg}))
        else $error("delete shift walked past the tail");
`endif

endmodule
